// ===== hw/rtl/oit_fragment_feature_compositor_defines.svh =====
// Assertion macros used by the compositor checker.
`ifndef OIT_FRAGMENT_FEATURE_COMPOSITOR_DEFINES_SVH
`define OIT_FRAGMENT_FEATURE_COMPOSITOR_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define OITC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define OITC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checked on the first edge after reset is released.
`define OITC_ASSERT_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk_i) $rose(rst_ni) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/oitc_pkg.sv =====
// Shared constants, types and codes of the fragment compositor.
package oitc_pkg;

  localparam int MAX_FRAGMENTS = 16;
  localparam int FRAC_BITS     = 16;
  localparam int VAL_W         = FRAC_BITS + 1;
  localparam int SUM_W         = 21;
  localparam int CNT_W         = $clog2(MAX_FRAGMENTS + 1);
  localparam int DIV_CNT_W     = $clog2(SUM_W);
  localparam int NUM_CH        = 4;
  localparam int NUM_COL       = 3;
  localparam int CH_W          = 2;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int IN_W      = NUM_CH * VAL_W;
  localparam int S_TDATA_W = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W     = 3 * VAL_W + SUM_W + 2;
  localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [VAL_W-1:0] ONE_FX  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CH_W-1:0]  CH_ALPHA = 2'd3;

  typedef enum logic [1:0] {
    KIND_FRONT = 2'd0,
    KIND_REST  = 2'd1,
    KIND_DROP  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_FEW = 2'd1,
    ST_OVF = 2'd2
  } status_e;

  typedef struct packed {
    logic             last;
    kind_e            kind;
    logic [VAL_W-1:0] alpha;
    logic [VAL_W-1:0] blue;
    logic [VAL_W-1:0] green;
    logic [VAL_W-1:0] red;
  } frag_t;

endpackage

// ===== hw/rtl/oitc_front.sv =====
// Input side: accepts fragments, clamps channels and tags each by its place in the pixel.
module oitc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [oitc_pkg::S_TDATA_W-1:0] s_tdata_i,
  input  logic                           s_tlast_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output oitc_pkg::frag_t                q_entry_o
);
  import oitc_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [VAL_W-1:0] clamp_one(input logic [VAL_W-1:0] v);
    return (v > ONE_FX) ? ONE_FX : v;
  endfunction

  assign s_tready_o = !q_full_i;
  assign q_push_o   = s_tvalid_i && !q_full_i;

  always_comb begin
    q_entry_o.red   = clamp_one(s_tdata_i[0*VAL_W +: VAL_W]);
    q_entry_o.green = clamp_one(s_tdata_i[1*VAL_W +: VAL_W]);
    q_entry_o.blue  = clamp_one(s_tdata_i[2*VAL_W +: VAL_W]);
    q_entry_o.alpha = clamp_one(s_tdata_i[3*VAL_W +: VAL_W]);
    q_entry_o.last  = s_tlast_i;
    if (cnt_q < CNT_W'(2)) begin
      q_entry_o.kind = KIND_FRONT;
    end else if (cnt_q < CNT_W'(MAX_FRAGMENTS)) begin
      q_entry_o.kind = KIND_REST;
    end else begin
      q_entry_o.kind = KIND_DROP;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (q_push_o) begin
      if (s_tlast_i) begin
        cnt_d = '0;
      end else if (cnt_q < CNT_W'(MAX_FRAGMENTS)) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/oitc_queue.sv =====
// Short fragment queue between the input side and the compute side.
module oitc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  oitc_pkg::frag_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output oitc_pkg::frag_t head_o
);
  import oitc_pkg::*;

  frag_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? next_ptr(wr_q) : wr_q;
    rd_d  = pop_i ? next_ptr(rd_q) : rd_q;
    cnt_d = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + QCNT_W'(1);
      2'b01:   cnt_d = cnt_q - QCNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

// ===== hw/rtl/oitc_back.sv =====
// Compute side: blends, sums, per-pixel averaging divider and result output.
module oitc_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  input  oitc_pkg::frag_t                q_head_i,
  output logic                           q_pop_o,
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [oitc_pkg::M_TDATA_W-1:0] m_tdata_o,
  output logic [oitc_pkg::CH_W-1:0]      m_tuser_o,
  output logic                           m_tlast_o
);
  import oitc_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_ACC  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 ovf_q, ovf_d;
  logic [SUM_W-1:0]     rest_q [NUM_CH];
  logic [SUM_W-1:0]     rest_d [NUM_CH];
  logic [SUM_W-1:0]     pre_q [NUM_COL];
  logic [SUM_W-1:0]     pre_d [NUM_COL];
  logic [VAL_W-1:0]     trn_q, trn_d;
  logic [VAL_W-1:0]     fb_q [NUM_CH];
  logic [VAL_W-1:0]     fb_d [NUM_CH];
  logic [VAL_W-1:0]     tb_q [NUM_CH];
  logic [VAL_W-1:0]     tb_d [NUM_CH];
  logic [CNT_W-1:0]     rem_q [NUM_CH];
  logic [CNT_W-1:0]     rem_d [NUM_CH];
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic [CH_W-1:0]      ch_q, ch_d;
  logic                 m_valid_q, m_valid_d;

  // working fragment and first-stage products
  logic [VAL_W-1:0]     frag_q [NUM_CH];
  logic [VAL_W-1:0]     head_c [NUM_CH];
  kind_e                kind_q;
  logic                 last_q;
  logic [VAL_W-1:0]     wt_t_q, wt_t_d, wt_f_q, wt_f_d, tr_q, tr_d;
  logic [VAL_W-1:0]     pm_q [NUM_COL];
  logic [VAL_W-1:0]     pm_d [NUM_COL];

  logic [M_TDATA_W-1:0] m_data_q, m_data_d;
  logic [CH_W-1:0]      m_user_q;
  logic                 m_last_q;

  logic                 few;
  logic                 out_load;
  logic [CNT_W-1:0]     div_d;
  logic [CNT_W:0]       shifted [NUM_CH];
  logic [CNT_W:0]       rem_sub [NUM_CH];
  logic                 ge [NUM_CH];
  logic [VAL_W-1:0]     avg_sel;
  logic [SUM_W-1:0]     acc_sel;
  status_e              status;

  function automatic logic [VAL_W-1:0] fx_mul(input logic [VAL_W-1:0] a,
                                              input logic [VAL_W-1:0] b);
    logic [2*VAL_W-1:0] p;
    p = a * b;
    return p[FRAC_BITS +: VAL_W];
  endfunction

  function automatic logic [VAL_W-1:0] blend_add(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, ONE_FX}) ? ONE_FX : s[VAL_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                               input logic [VAL_W-1:0] v);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + (SUM_W + 1)'(v);
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  assign head_c[0] = q_head_i.red;
  assign head_c[1] = q_head_i.green;
  assign head_c[2] = q_head_i.blue;
  assign head_c[3] = q_head_i.alpha;

  assign few      = (cnt_q < CNT_W'(3));
  assign div_d    = cnt_q - CNT_W'(2);
  assign out_load = (state_q == S_OUT) && (!m_valid_q || m_tready_i);
  assign q_pop_o  = (state_q == S_LOAD) && q_valid_i;

  // first-stage products, taken straight from the queue head
  always_comb begin
    wt_t_d = fx_mul(ONE_FX - tb_q[3], q_head_i.alpha);
    wt_f_d = fx_mul(ONE_FX - fb_q[3], q_head_i.alpha);
    tr_d   = fx_mul(trn_q, ONE_FX - q_head_i.alpha);
    for (int c = 0; c < NUM_COL; c++) begin
      pm_d[c] = fx_mul(head_c[c], q_head_i.alpha);
    end
  end

  // restoring divider lanes, one quotient bit per cycle
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      shifted[c] = {rem_q[c], rest_q[c][SUM_W-1]};
      ge[c]      = (shifted[c] >= {1'b0, div_d});
      rem_sub[c] = ge[c] ? (shifted[c] - {1'b0, div_d}) : shifted[c];
    end
  end

  // result selection for the current channel
  always_comb begin
    avg_sel = few ? '0 : rest_q[ch_q][VAL_W-1:0];
    case (ch_q)
      2'd0:    acc_sel = pre_q[0];
      2'd1:    acc_sel = pre_q[1];
      2'd2:    acc_sel = pre_q[2];
      default: acc_sel = SUM_W'(trn_q);
    endcase
    if (ovf_q) begin
      status = ST_OVF;
    end else if (few) begin
      status = ST_FEW;
    end else begin
      status = ST_OK;
    end
    m_data_d = M_TDATA_W'({status, tb_q[ch_q], fb_q[ch_q], acc_sel, avg_sel});
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    trn_d     = trn_q;
    rest_d    = rest_q;
    pre_d     = pre_q;
    fb_d      = fb_q;
    tb_d      = tb_q;
    rem_d     = rem_q;
    div_cnt_d = div_cnt_q;
    ch_d      = ch_q;

    if (state_q != S_DIV) begin
      rem_d     = '{default: '0};
      div_cnt_d = '0;
    end
    if (state_q != S_OUT) begin
      ch_d = '0;
    end

    case (state_q)
      S_LOAD: begin
        if (q_valid_i) begin
          if (q_head_i.kind == KIND_DROP) begin
            ovf_d = 1'b1;
            if (q_head_i.last) begin
              state_d = S_DIV;
            end
          end else begin
            state_d = S_ACC;
          end
        end
      end
      S_ACC: begin
        for (int c = 0; c < NUM_COL; c++) begin
          tb_d[c]  = blend_add(tb_q[c], fx_mul(frag_q[c], wt_t_q));
          pre_d[c] = sat_add(pre_q[c], pm_q[c]);
          if (kind_q == KIND_FRONT) begin
            fb_d[c] = blend_add(fb_q[c], fx_mul(frag_q[c], wt_f_q));
          end
        end
        tb_d[3] = blend_add(tb_q[3], wt_t_q);
        if (kind_q == KIND_FRONT) begin
          fb_d[3] = blend_add(fb_q[3], wt_f_q);
        end
        if (kind_q == KIND_REST) begin
          for (int c = 0; c < NUM_CH; c++) begin
            rest_d[c] = sat_add(rest_q[c], frag_q[c]);
          end
        end
        trn_d   = tr_q;
        cnt_d   = cnt_q + CNT_W'(1);
        state_d = last_q ? S_DIV : S_LOAD;
      end
      S_DIV: begin
        if (few) begin
          state_d = S_OUT;
        end else begin
          for (int c = 0; c < NUM_CH; c++) begin
            rem_d[c]  = rem_sub[c][CNT_W-1:0];
            rest_d[c] = {rest_q[c][SUM_W-2:0], ge[c]};
          end
          div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
          if (div_cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (out_load) begin
          if (ch_q == CH_ALPHA) begin
            state_d = S_LOAD;
            cnt_d   = '0;
            ovf_d   = 1'b0;
            trn_d   = ONE_FX;
            rest_d  = '{default: '0};
            pre_d   = '{default: '0};
            fb_d    = '{default: '0};
            tb_d    = '{default: '0};
          end else begin
            ch_d = ch_q + CH_W'(1);
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_comb begin
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_tready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      trn_q     <= ONE_FX;
      rest_q    <= '{default: '0};
      pre_q     <= '{default: '0};
      fb_q      <= '{default: '0};
      tb_q      <= '{default: '0};
      rem_q     <= '{default: '0};
      div_cnt_q <= '0;
      ch_q      <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      trn_q     <= trn_d;
      rest_q    <= rest_d;
      pre_q     <= pre_d;
      fb_q      <= fb_d;
      tb_q      <= tb_d;
      rem_q     <= rem_d;
      div_cnt_q <= div_cnt_d;
      ch_q      <= ch_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      frag_q <= head_c;
      kind_q <= q_head_i.kind;
      last_q <= q_head_i.last;
      wt_t_q <= wt_t_d;
      wt_f_q <= wt_f_d;
      tr_q   <= tr_d;
      pm_q   <= pm_d;
    end
    if (out_load) begin
      m_data_q <= m_data_d;
      m_user_q <= ch_q;
      m_last_q <= (ch_q == CH_ALPHA);
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tuser_o  = m_user_q;
  assign m_tlast_o  = m_last_q;

endmodule

// ===== hw/rtl/oit_fragment_feature_compositor.sv =====
// Top level of the front-to-back fragment compositor.
// Per fragment: queue pop with first products, then accumulate; drops are only popped.
// Pixel close: last fragment, then a bit-serial divider on the sums (skipped with fewer
// than three fragments), then four results, one per cycle while the sink is ready.
// Reset: asynchronous; empties the queue, zeroes counts and sums, transmittance to 1.0.
module oit_fragment_feature_compositor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // red, green, blue, alpha (17 bits each), zero padding
  input  logic [oitc_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  input  logic                           s_axis_tlast_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // average (17), accumulation (21), front_two (17), total (17), status (2), padding
  output logic [oitc_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  // channel
  output logic [oitc_pkg::CH_W-1:0]      m_axis_tuser_o,
  output logic                           m_axis_tlast_o
);
  import oitc_pkg::*;

  logic  q_push, q_full, q_pop, q_valid;
  frag_t q_entry, q_head;

  oitc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tlast_i  (s_axis_tlast_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_entry)
  );

  oitc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  oitc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ===== hw/rtl/oitc_checker.sv =====
// Port-level checks of the compositor result stream, bound to the top level.
`include "oit_fragment_feature_compositor_defines.svh"

module oitc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [oitc_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  input logic [oitc_pkg::CH_W-1:0]      m_axis_tuser_o,
  input logic                           m_axis_tlast_o
);
  import oitc_pkg::*;

  logic out_xfer;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;

  `OITC_ASSERT_NEXT(a_stall_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o), "result changed while stalled")
  `OITC_ASSERT_NEXT(a_burst_cont, out_xfer && !m_axis_tlast_o, m_axis_tvalid_o, "gap inside a pixel's results")
  `OITC_ASSERT_NEXT(a_chan_step, out_xfer && !m_axis_tlast_o, m_axis_tuser_o == $past(m_axis_tuser_o) + CH_W'(1), "channel order broken")
  `OITC_ASSERT_RESET(a_reset_idle, !m_axis_tvalid_o, "result valid right after reset")

endmodule

bind oit_fragment_feature_compositor oitc_checker u_checker (.*);
